[hw/rtl/bbps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbps_pkg
// Shared widths and constants of the bouncing ball frame step.
// ----------------------------------------------------------------------------
package bbps_pkg;
  localparam int FracBits = 8;
  localparam int ValW     = 24;
  localparam int DtBits   = 16;
  localparam int RestBits = 8;
  localparam int Gravity  = 981;
  localparam int DivW     = 13 + FracBits + DtBits;

  localparam logic [2:0] CfgRadius = 3'd0;
  localparam logic [2:0] CfgRest   = 3'd1;
  localparam logic [2:0] CfgSpx    = 3'd2;
  localparam logic [2:0] CfgSpy    = 3'd3;
  localparam logic [2:0] CfgSvx    = 3'd4;
  localparam logic [2:0] CfgSvy    = 3'd5;

  localparam logic signed [ValW-1:0] VMax = {1'b0, {(ValW-1){1'b1}}};
  localparam logic signed [ValW-1:0] VMin = {1'b1, {(ValW-1){1'b0}}};

  function automatic logic signed [ValW-1:0] sat24(input logic signed [63:0] x);
    if (x > 64'(VMax)) return VMax;
    if (x < 64'(VMin)) return VMin;
    return x[ValW-1:0];
  endfunction
endpackage
`default_nettype wire

[hw/rtl/bouncing_ball_physics_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bouncing_ball_physics_step
// One frame of ball motion: drag, throw, gravity, Euler move, wall bounces.
// ----------------------------------------------------------------------------
// One transaction is one frame. A frame runs through one shared multiplier under
// a sequencer: pressing the button adds a distance check, a held ball skips the
// physics states, and a release that throws the ball adds two runs of a
// bit-serial divider. The result waits in output registers and in_ready_o stays
// low from acceptance until the cycle after it is taken.
module bouncing_ball_physics_step import bbps_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        restore_i,
  input  wire logic        button_pressed_i,
  input  wire logic        button_released_i,
  input  wire logic [11:0] mouse_x_i,
  input  wire logic [11:0] mouse_y_i,
  input  wire logic signed [12:0] mouse_dx_i,
  input  wire logic signed [12:0] mouse_dy_i,
  input  wire logic [15:0] frame_dt_i,
  input  wire logic [11:0] screen_w_i,
  input  wire logic [11:0] screen_h_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic signed [ValW-1:0] pos_x_o,
  output logic signed [ValW-1:0] pos_y_o,
  output logic signed [ValW-1:0] vel_x_o,
  output logic signed [ValW-1:0] vel_y_o,
  output logic             held_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [23:0] cfg_data_i
);
  typedef enum logic [3:0] {
    S_IDLE, S_DX, S_DY, S_CMP, S_DIVX, S_DIVY, S_GRAV, S_MVX, S_MVY,
    S_WR, S_WL, S_WT, S_WB, S_OUT
  } state_e;

  state_e state_q;
  logic [10:0] rad_q;
  logic [8:0]  rest_q;
  logic signed [ValW-1:0] spx_q, spy_q, svx_q, svy_q;
  logic signed [ValW-1:0] px_q, py_q, vx_q, vy_q;
  logic drag_q;
  logic rel_q;
  logic prs_q;
  logic [11:0] mx_q, my_q, sw_q, sh_q;
  logic signed [12:0] mdx_q, mdy_q;
  logic [15:0] dt_q;
  logic signed [63:0] acc_q;
  // divider
  logic [DivW-1:0] rem_q, quo_q;
  logic [5:0] cnt_q;
  logic neg_q;

  // shared multiplier operands
  logic signed [33:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [63:0] r64, mxs, mys, sws, shs;

  assign r64 = 64'(rad_q) <<< FracBits;
  assign mxs = 64'(mx_q) <<< FracBits;
  assign mys = 64'(my_q) <<< FracBits;
  assign sws = 64'(sw_q) <<< FracBits;
  assign shs = 64'(sh_q) <<< FracBits;

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_q)
      S_DX:   begin ma = 34'(mxs - 64'(px_q)); mb = ma; end
      S_DY:   begin ma = 34'(mys - 64'(py_q)); mb = ma; end
      S_CMP:  begin ma = 34'(r64); mb = ma; end
      S_GRAV: begin ma = 34'(Gravity << FracBits); mb = 34'(dt_q); end
      S_MVX:  begin ma = 34'(vx_q); mb = 34'(dt_q); end
      S_MVY:  begin ma = 34'(vy_q); mb = 34'(dt_q); end
      S_WR, S_WL: begin ma = -34'(vx_q); mb = 34'(rest_q); end
      S_WT, S_WB: begin ma = -34'(vy_q); mb = 34'(rest_q); end
      default: ;
    endcase
  end
  assign prod = 64'(ma) * 64'(mb);

  function automatic logic signed [63:0] rsh(input logic signed [63:0] x, input int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  logic signed [12:0] dsel;
  logic [DivW-1:0] dmag;
  logic [DivW:0] trial;
  // horizontal delta is loaded when leaving S_CMP, vertical when leaving S_DIVX
  assign dsel  = (state_q == S_CMP) ? mdx_q : mdy_q;
  assign dmag  = DivW'(dsel[12] ? -64'(dsel) : 64'(dsel)) << (FracBits + DtBits);
  assign trial = {rem_q, quo_q[DivW-1]} - {1'b0, {(DivW-16){1'b0}}, dt_q};

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rad_q <= 11'd50;
      rest_q <= 9'd230;
      spx_q <= 24'sd25600;  spy_q <= 24'sd128000;
      svx_q <= 24'sd51200;  svy_q <= -24'sd51200;
      px_q <= 24'sd25600;   py_q <= 24'sd128000;
      vx_q <= 24'sd51200;   vy_q <= -24'sd51200;
      drag_q <= 1'b0;
      out_valid_o <= 1'b0;
      rel_q <= 1'b0;
      prs_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgRadius: rad_q  <= cfg_data_i[10:0];
          CfgRest:   rest_q <= cfg_data_i[8:0];
          CfgSpx:    spx_q  <= cfg_data_i;
          CfgSpy:    spy_q  <= cfg_data_i;
          CfgSvx:    svx_q  <= cfg_data_i;
          CfgSvy:    svy_q  <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: if (in_valid_i) begin
          mx_q <= mouse_x_i;  my_q <= mouse_y_i;
          mdx_q <= mouse_dx_i; mdy_q <= mouse_dy_i;
          dt_q <= frame_dt_i; sw_q <= screen_w_i; sh_q <= screen_h_i;
          rel_q <= button_released_i;
          prs_q <= button_pressed_i;
          if (restore_i) begin
            px_q <= spx_q; py_q <= spy_q; vx_q <= svx_q; vy_q <= svy_q;
          end
          state_q <= button_pressed_i ? S_DX : S_CMP;
          acc_q <= '0;
          if (!button_pressed_i) state_q <= S_CMP;
        end
        S_DX: begin acc_q <= prod; state_q <= S_DY; end
        S_DY: begin acc_q <= acc_q + prod; state_q <= S_CMP; end
        S_CMP: begin
          // acc holds the squared distance when pressed
          logic grab;
          grab = prs_q && acc_q <= prod;
          if (grab) drag_q <= 1'b1;
          if (rel_q) begin
            if ((drag_q || grab) && dt_q != '0) begin
              neg_q <= mdx_q[12];
              quo_q <= dmag; rem_q <= '0; cnt_q <= 6'(DivW);
              state_q <= S_DIVX;
            end else begin
              drag_q <= 1'b0;
              state_q <= S_GRAV;
            end
          end else state_q <= (drag_q || grab) ? S_OUT : S_GRAV;
          if (!rel_q && (drag_q || grab)) begin
            vx_q <= '0; vy_q <= '0; px_q <= sat24(mxs); py_q <= sat24(mys);
          end
        end
        S_DIVX, S_DIVY: begin
          if (cnt_q != '0) begin
            if (!trial[DivW]) rem_q <= trial[DivW-1:0];
            else rem_q <= {rem_q[DivW-2:0], quo_q[DivW-1]};
            quo_q <= {quo_q[DivW-2:0], !trial[DivW]};
            cnt_q <= cnt_q - 6'd1;
          end else if (state_q == S_DIVX) begin
            vx_q <= sat24(neg_q ? -64'(quo_q) : 64'(quo_q));
            neg_q <= mdy_q[12];
            quo_q <= dmag; rem_q <= '0; cnt_q <= 6'(DivW);
            rel_q <= 1'b0;
            state_q <= S_DIVY;
          end else begin
            vy_q <= sat24(neg_q ? -64'(quo_q) : 64'(quo_q));
            drag_q <= 1'b0;
            state_q <= S_GRAV;
          end
        end
        S_GRAV: begin
          vy_q <= sat24(64'(vy_q) + rsh(prod, DtBits));
          state_q <= S_MVX;
        end
        S_MVX: begin
          px_q <= sat24(64'(px_q) + rsh(prod, DtBits));
          state_q <= S_MVY;
        end
        S_MVY: begin
          py_q <= sat24(64'(py_q) + rsh(prod, DtBits));
          state_q <= S_WR;
        end
        S_WR: begin
          if (64'(px_q) + r64 >= sws) begin
            vx_q <= sat24(rsh(prod, RestBits));
            px_q <= sat24(2 * sws - 2 * r64 - 64'(px_q));
          end
          state_q <= S_WL;
        end
        S_WL: begin
          if (64'(px_q) - r64 <= 0) begin
            vx_q <= sat24(rsh(prod, RestBits));
            px_q <= sat24(2 * r64 - 64'(px_q));
          end
          state_q <= S_WT;
        end
        S_WT: begin
          if (64'(py_q) - r64 <= 0) begin
            vy_q <= sat24(rsh(prod, RestBits));
            py_q <= sat24(2 * r64 - 64'(py_q));
          end
          state_q <= S_WB;
        end
        S_WB: begin
          if (64'(py_q) + r64 >= shs) begin
            vy_q <= sat24(rsh(prod, RestBits));
            py_q <= sat24(2 * shs - 2 * r64 - 64'(py_q));
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_o) begin
            out_valid_o <= 1'b1;
            pos_x_o <= px_q; pos_y_o <= py_q; vel_x_o <= vx_q; vel_y_o <= vy_q;
            held_o <= drag_q;
          end else if (out_ready_i) begin
            out_valid_o <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pos_x_o))
    else $error("result dropped");
  a_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && held_o |-> vel_x_o == '0 && vel_y_o == '0)
    else $error("dragged ball moving");
endmodule
`default_nettype wire
